/* design/nnhco_pkg.sv */
// Package for the nearest neighbor hit chain orderer.
// Shared widths, codes and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package nnhco_pkg;

    localparam int MAX_HITS  = 64;
    localparam int WIRE_BITS = 13;
    localparam int TIME_BITS = 18;
    localparam int IDX_W     = $clog2(MAX_HITS);
    localparam int CNT_W     = $clog2(MAX_HITS + 1);
    localparam int GAP_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int STATUS_W  = 2;

    // signed differences and squared distance (tick^2, one wire step weighted as 16 ticks)
    localparam int DT_W  = TIME_BITS + 1;
    localparam int DW_W  = WIRE_BITS + 1;
    localparam int SQ_W  = ((2 * DT_W > 2 * DW_W + 8) ? 2 * DT_W : 2 * DW_W + 8) + 1;
    localparam int ROOT_W = (SQ_W + 1) / 2;
    localparam int LIM_W = CFG_W + 1;

    localparam int RECENT_N = 6;

    localparam logic [GAP_W-1:0] GAP_MAX      = '1;
    localparam logic [LIM_W-1:0] BRIDGE_EXTRA = LIM_W'(800);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ORDER = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_START = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE   = 8'd1;

    typedef struct packed {
        logic load;
        logic err;
        logic st_rd;
        logic st_lat;
        logic scan_go;
        logic dec_go;
        logic apply;
        logic fin;
        logic out_rd2;
        logic out_lat;
        logic out_wr;
        logic swap;
    } t_cmd;

    typedef struct packed {
        logic is_order;
        logic start_set;
        logic start_oor;
        logic rem_zero;
        logic scan_done;
        logic sqrt_done;
        logic out_last;
    } t_sts;

endpackage

/* design/nearest_neighbor_hit_chain_orderer.sv */
// Nearest neighbor hit chain orderer, top level.
// A load transaction (tuser 0) stores one hit; loads beyond 64 hits are
// ignored. An order transaction (tuser 1) builds the chain from the start hit: each
// search step scans the hit memory at one hit per cycle and then takes the bit-serial
// square root of the gap, and the whole run completes before the first result.
// Results then leave one by one, each read from the chain memory and then the hit
// memory. After the run the chain replaces the stored hits.
// A bad start gives one result with an error status.
// Depends on nnhco_pkg, nnhco_ctrl and nnhco_dp.
`timescale 1ns / 1ps

module nearest_neighbor_hit_chain_orderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [12:0] hit_wire, [30:13] hit_time, [31] start_set, [37:32] start_index
    input  logic [39:0] s_axis_tdata,
    // [0] command
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [12:0] out_wire, [30:13] out_time, [46:31] gap_distance
    output logic [47:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    nnhco_pkg::t_cmd cmd;
    nnhco_pkg::t_sts sts;
    logic [nnhco_pkg::WIRE_BITS-1:0] out_wire;
    logic [nnhco_pkg::TIME_BITS-1:0] out_time;
    logic [nnhco_pkg::GAP_W-1:0]     out_gap;

    assign o_cfg_ready = 1'b1;

    nnhco_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .o_s_ready(s_axis_tready),
        .o_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_sts(sts), .o_cmd(cmd));

    nnhco_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_sts(sts),
        .i_command(s_axis_tuser[0]),
        .i_hit_wire(s_axis_tdata[12:0]),
        .i_hit_time(s_axis_tdata[30:13]),
        .i_start_set(s_axis_tdata[31]),
        .i_start_index(s_axis_tdata[37:32]),
        .i_cfg_we(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_wire(out_wire), .o_time(out_time), .o_gap(out_gap),
        .o_status(m_axis_tuser), .o_last(m_axis_tlast));

    assign m_axis_tdata = {1'b0, out_gap, out_time, out_wire};

    // input side only opens while no result is pending
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is pending");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != nnhco_pkg::ST_OK) |-> m_axis_tlast)
        else $error("error result not marked last");

    a_error_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != nnhco_pkg::ST_OK) |-> (m_axis_tdata == '0))
        else $error("error result carries data");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block not idle after final result");

endmodule

/* design/nnhco_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nnhco_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/nnhco_sqrt.sv */
// Iterative integer square root, one result bit per cycle, floored.
// Depends on nnhco_pkg for the operand and root widths.
`timescale 1ns / 1ps

module nnhco_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [nnhco_pkg::SQ_W-1:0]   i_value,
    output logic                         o_done,
    output logic [nnhco_pkg::ROOT_W-1:0] o_root
);

    localparam int OP_W = 2 * nnhco_pkg::ROOT_W;
    localparam int IT_W = $clog2(nnhco_pkg::ROOT_W);

    logic [OP_W-1:0] r_v, r_r, r_bit;
    logic [IT_W-1:0] r_cnt;
    logic            r_busy, r_done;
    logic [OP_W-1:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= OP_W'(i_value);
            r_r   <= '0;
            r_bit <= OP_W'(1) << (OP_W - 2);
            r_cnt <= IT_W'(nnhco_pkg::ROOT_W - 1);
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[nnhco_pkg::ROOT_W-1:0];

endmodule

/* design/nnhco_ctrl.sv */
// Controller state machine: sequences load, search steps and result readout.
// Depends on nnhco_pkg for the command and status structs.
`timescale 1ns / 1ps

module nnhco_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    input  nnhco_pkg::t_sts   i_sts,
    output nnhco_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_PICK  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_APPLY = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_OUTA  = 4'd7;
    localparam logic [3:0] S_OUTB  = 4'd8;
    localparam logic [3:0] S_OUTC  = 4'd9;
    localparam logic [3:0] S_SEND  = 4'd10;
    localparam logic [3:0] S_ESEND = 4'd11;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    if (!i_sts.is_order) begin
                        o_cmd.load = 1'b1;
                    end else if (!i_sts.start_set || i_sts.start_oor) begin
                        o_cmd.err = 1'b1;
                        n_state   = S_ESEND;
                    end else begin
                        o_cmd.st_rd = 1'b1;
                        n_state     = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.st_lat = 1'b1;
                n_state      = S_PICK;
            end
            S_PICK: begin
                if (i_sts.rem_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.scan_go = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.dec_go = 1'b1;
                    n_state      = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_PICK;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUTA;
            end
            S_OUTA: begin
                n_state = S_OUTB;
            end
            S_OUTB: begin
                o_cmd.out_rd2 = 1'b1;
                n_state       = S_OUTC;
            end
            S_OUTC: begin
                o_cmd.out_lat = 1'b1;
                n_state       = S_SEND;
            end
            S_SEND: begin
                if (i_m_ready) begin
                    o_cmd.out_wr = 1'b1;
                    if (i_sts.out_last) begin
                        o_cmd.swap = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_OUTA;
                    end
                end
            end
            S_ESEND: begin
                if (i_m_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = (r_state == S_SEND) || (r_state == S_ESEND);

endmodule

/* design/nnhco_dp.sv */
// Datapath: hit stores (two banks), chain and gap memories, distance search
// pipeline, gap bridging test, square root unit and the result register.
// Depends on nnhco_pkg, nnhco_ram and nnhco_sqrt.
`timescale 1ns / 1ps

module nnhco_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  nnhco_pkg::t_cmd                       i_cmd,
    output nnhco_pkg::t_sts                       o_sts,
    input  logic                                  i_command,
    input  logic [nnhco_pkg::WIRE_BITS-1:0]       i_hit_wire,
    input  logic [nnhco_pkg::TIME_BITS-1:0]       i_hit_time,
    input  logic                                  i_start_set,
    input  logic [nnhco_pkg::IDX_W-1:0]           i_start_index,
    input  logic                                  i_cfg_we,
    input  logic [nnhco_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nnhco_pkg::CFG_W-1:0]           i_cfg_data,
    output logic [nnhco_pkg::WIRE_BITS-1:0]       o_wire,
    output logic [nnhco_pkg::TIME_BITS-1:0]       o_time,
    output logic [nnhco_pkg::GAP_W-1:0]           o_gap,
    output logic [nnhco_pkg::STATUS_W-1:0]        o_status,
    output logic                                  o_last
);

    localparam int WB = nnhco_pkg::WIRE_BITS;
    localparam int TB = nnhco_pkg::TIME_BITS;
    localparam int IW = nnhco_pkg::IDX_W;
    localparam int CW = nnhco_pkg::CNT_W;
    localparam int DT = nnhco_pkg::DT_W;
    localparam int DW = nnhco_pkg::DW_W;
    localparam int SQ = nnhco_pkg::SQ_W;
    localparam int GW = nnhco_pkg::GAP_W;
    localparam int FW = nnhco_pkg::CFG_W;
    localparam int LW = nnhco_pkg::LIM_W;
    localparam int PW = DT + DW;
    localparam int RN = nnhco_pkg::RECENT_N;
    localparam int THW = FW + WB;
    localparam int RHW = FW + 2 * WB;
    localparam int CMPW = (RHW > PW + 5) ? RHW : PW + 5;

    // configuration
    logic [FW-1:0]   r_mgd, r_thr;
    logic [2*FW-1:0] r_mgd_sq;
    logic [2*LW-1:0] r_lim_sq;
    logic [LW-1:0]   lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mgd <= '0;
            r_thr <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == nnhco_pkg::REG_MAX_GAP) begin
                r_mgd <= i_cfg_data;
            end else if (i_cfg_index == nnhco_pkg::REG_SLOPE) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    assign lim = LW'(r_mgd) + nnhco_pkg::BRIDGE_EXTRA;

    always_ff @(posedge i_clk) begin
        r_mgd_sq <= r_mgd * r_mgd;
        r_lim_sq <= lim * lim;
    end

    // control state
    logic          r_bank;
    logic [CW-1:0] r_loaded, r_clen, r_rem, r_k;
    logic [nnhco_pkg::MAX_HITS-1:0] r_taken;
    logic [IW-1:0] r_start;
    logic [2:0]    r_acc;
    logic          r_scan_run;
    logic [CW-1:0] r_scan_i;
    logic          r_s1_vld, r_s2_vld, r_found;
    logic [IW-1:0] r_s1_idx, r_s2_idx, r_best_idx;

    // payload state
    logic [WB-1:0] r_last_w, r_s2_w, r_best_w;
    logic [TB-1:0] r_last_t, r_s2_t, r_best_t;
    logic [WB-1:0] r_rw [RN];
    logic [TB-1:0] r_rt [RN];
    logic [2*DT-1:0] r_s2_dt2;
    logic [2*DW-1:0] r_s2_dw2;
    logic [SQ-1:0]   r_best_sq;
    logic [GW-1:0]   r_gap_last;

    // memories
    logic [WB-1:0] wa_rd, wb_rd, hit_w;
    logic [TB-1:0] ta_rd, tb_rd, hit_t;
    logic [IW-1:0] chain_rd, hit_raddr, hit_waddr, chain_waddr, gap_waddr;
    logic [GW-1:0] gap_rd, gap_wdata;
    logic [IW-1:0] chain_wdata;
    logic          load_we, we_a, we_b, chain_we, gap_we;
    logic [WB-1:0] hit_wdata_w;
    logic [TB-1:0] hit_wdata_t;

    logic acc_ok;
    logic [GW-1:0] gap_sat;
    logic sqrt_done;
    logic [nnhco_pkg::ROOT_W-1:0] root;

    assign load_we = i_cmd.load && (r_loaded < CW'(nnhco_pkg::MAX_HITS));
    assign we_a    = (load_we && !r_bank) || (i_cmd.out_wr && r_bank);
    assign we_b    = (load_we && r_bank) || (i_cmd.out_wr && !r_bank);
    assign hit_waddr   = i_cmd.load ? r_loaded[IW-1:0] : r_k[IW-1:0];
    assign hit_wdata_w = i_cmd.load ? i_hit_wire : o_wire;
    assign hit_wdata_t = i_cmd.load ? i_hit_time : o_time;

    always_comb begin
        if (i_cmd.st_rd) begin
            hit_raddr = i_start_index;
        end else if (i_cmd.out_rd2) begin
            hit_raddr = chain_rd;
        end else begin
            hit_raddr = r_scan_i[IW-1:0];
        end
    end

    assign hit_w = r_bank ? wb_rd : wa_rd;
    assign hit_t = r_bank ? tb_rd : ta_rd;

    assign chain_we    = i_cmd.st_lat || (i_cmd.apply && acc_ok);
    assign chain_waddr = i_cmd.st_lat ? '0 : r_clen[IW-1:0];
    assign chain_wdata = i_cmd.st_lat ? r_start : r_best_idx;

    assign gap_we    = (i_cmd.apply && acc_ok) || i_cmd.fin;
    assign gap_waddr = IW'(r_clen - 1'b1);
    assign gap_wdata = i_cmd.fin
        ? ((r_loaded == CW'(1)) ? nnhco_pkg::GAP_MAX : r_gap_last) : gap_sat;

    nnhco_ram #(.WIDTH(WB), .DEPTH(nnhco_pkg::MAX_HITS)) u_wire_a (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(hit_waddr), .i_wdata(hit_wdata_w),
        .i_raddr(hit_raddr), .o_rdata(wa_rd));
    nnhco_ram #(.WIDTH(WB), .DEPTH(nnhco_pkg::MAX_HITS)) u_wire_b (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(hit_waddr), .i_wdata(hit_wdata_w),
        .i_raddr(hit_raddr), .o_rdata(wb_rd));
    nnhco_ram #(.WIDTH(TB), .DEPTH(nnhco_pkg::MAX_HITS)) u_time_a (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(hit_waddr), .i_wdata(hit_wdata_t),
        .i_raddr(hit_raddr), .o_rdata(ta_rd));
    nnhco_ram #(.WIDTH(TB), .DEPTH(nnhco_pkg::MAX_HITS)) u_time_b (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(hit_waddr), .i_wdata(hit_wdata_t),
        .i_raddr(hit_raddr), .o_rdata(tb_rd));
    nnhco_ram #(.WIDTH(IW), .DEPTH(nnhco_pkg::MAX_HITS)) u_chain (
        .i_clk(i_clk), .i_we(chain_we), .i_waddr(chain_waddr), .i_wdata(chain_wdata),
        .i_raddr(r_k[IW-1:0]), .o_rdata(chain_rd));
    nnhco_ram #(.WIDTH(GW), .DEPTH(nnhco_pkg::MAX_HITS)) u_gap (
        .i_clk(i_clk), .i_we(gap_we), .i_waddr(gap_waddr), .i_wdata(gap_wdata),
        .i_raddr(r_k[IW-1:0]), .o_rdata(gap_rd));

    // search pipeline: issue, square, compare
    logic signed [DT-1:0]   s1_dt;
    logic signed [DW-1:0]   s1_dw;
    logic signed [2*DT-1:0] s1_dt2;
    logic signed [2*DW-1:0] s1_dw2;
    logic [SQ-1:0]          s2_sq;

    assign s1_dt  = $signed({1'b0, hit_t}) - $signed({1'b0, r_last_t});
    assign s1_dw  = $signed({1'b0, hit_w}) - $signed({1'b0, r_last_w});
    assign s1_dt2 = s1_dt * s1_dt;
    assign s1_dw2 = s1_dw * s1_dw;
    assign s2_sq  = SQ'(r_s2_dt2) + (SQ'(r_s2_dw2) << 8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank     <= 1'b0;
            r_loaded   <= '0;
            r_taken    <= '0;
            r_scan_run <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_acc      <= '0;
            r_clen     <= '0;
            r_rem      <= '0;
            r_k        <= '0;
        end else begin
            if (load_we) begin
                r_loaded <= r_loaded + 1'b1;
            end
            r_s1_vld <= r_scan_run && !r_taken[r_scan_i[IW-1:0]];
            r_s2_vld <= r_s1_vld;
            if (r_scan_run) begin
                r_scan_i <= r_scan_i + 1'b1;
                if (r_scan_i + 1'b1 == r_loaded) begin
                    r_scan_run <= 1'b0;
                end
            end
            if (r_s2_vld && (!r_found || s2_sq < r_best_sq)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.st_rd) begin
                r_taken <= '0;
                r_acc   <= '0;
                r_k     <= '0;
            end
            if (i_cmd.st_lat) begin
                r_taken[r_start] <= 1'b1;
                r_acc  <= r_acc + 1'b1;
                r_clen <= CW'(1);
                r_rem  <= r_loaded - 1'b1;
            end
            if (i_cmd.scan_go) begin
                r_scan_run <= 1'b1;
                r_scan_i   <= '0;
                r_found    <= 1'b0;
            end
            if (i_cmd.apply) begin
                r_taken[r_best_idx] <= 1'b1;
                r_rem <= r_rem - 1'b1;
                if (acc_ok) begin
                    r_clen <= r_clen + 1'b1;
                    if (r_acc != 3'(RN)) begin
                        r_acc <= r_acc + 1'b1;
                    end
                end
            end
            if (i_cmd.out_wr) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.swap) begin
                r_bank   <= !r_bank;
                r_loaded <= r_clen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_scan_i[IW-1:0];
        r_s2_idx <= r_s1_idx;
        r_s2_w   <= hit_w;
        r_s2_t   <= hit_t;
        r_s2_dt2 <= s1_dt2;
        r_s2_dw2 <= s1_dw2;
        if (r_s2_vld && (!r_found || s2_sq < r_best_sq)) begin
            r_best_sq  <= s2_sq;
            r_best_idx <= r_s2_idx;
            r_best_w   <= r_s2_w;
            r_best_t   <= r_s2_t;
        end
        if (i_cmd.st_rd) begin
            r_start <= i_start_index;
            for (int j = 0; j < RN; j++) begin
                r_rw[j] <= '0;
                r_rt[j] <= '0;
            end
        end
        // push the newly accepted hit into the recent window
        if (i_cmd.st_lat || (i_cmd.apply && acc_ok)) begin
            for (int j = 0; j < RN - 1; j++) begin
                r_rw[j] <= r_rw[j+1];
                r_rt[j] <= r_rt[j+1];
            end
            r_rw[RN-1] <= i_cmd.st_lat ? hit_w : r_best_w;
            r_rt[RN-1] <= i_cmd.st_lat ? hit_t : r_best_t;
            r_last_w   <= i_cmd.st_lat ? hit_w : r_best_w;
            r_last_t   <= i_cmd.st_lat ? hit_t : r_best_t;
        end
        if (i_cmd.apply) begin
            r_gap_last <= gap_sat;
        end
    end

    // gap bridging test, three registered stages off the best candidate
    logic signed [DT-1:0] a_d, c_d;
    logic signed [DW-1:0] b_d, d_d, b_abs, d_abs;
    logic signed [PW-1:0] r_d1_cb, r_d1_ad;
    logic [THW-1:0]       r_d1_thab;
    logic [WB-1:0]        r_d1_dabs;
    logic                 r_d1_prog, r_d1_lim, r_d1_dir;
    logic signed [PW:0]   d2_diff;
    logic [PW:0]          r_d2_abs;
    logic [RHW-1:0]       r_d2_rhs;
    logic                 r_d2_prog, r_d2_lim, r_d2_dir;
    logic                 r_bridge, r_direct;
    logic                 prog;
    logic [WB-1:0]        w1, w2, w3;

    assign w1 = r_rw[0];
    assign w2 = r_rw[RN-1];
    assign w3 = r_best_w;
    assign prog = ((w1 < w2) && (w3 > w2)) || ((w2 < w1) && (w3 < w2));
    assign a_d = $signed({1'b0, r_rt[RN-1]}) - $signed({1'b0, r_rt[0]});
    assign c_d = $signed({1'b0, r_best_t}) - $signed({1'b0, r_rt[RN-1]});
    assign b_d = $signed({1'b0, w2}) - $signed({1'b0, w1});
    assign d_d = $signed({1'b0, w3}) - $signed({1'b0, w2});
    assign b_abs = b_d[DW-1] ? -b_d : b_d;
    assign d_abs = d_d[DW-1] ? -d_d : d_d;
    assign d2_diff = (PW+1)'(r_d1_cb) - (PW+1)'(r_d1_ad);

    always_ff @(posedge i_clk) begin
        r_d1_cb   <= PW'(c_d * b_d);
        r_d1_ad   <= PW'(a_d * d_d);
        r_d1_thab <= r_thr * b_abs[WB-1:0];
        r_d1_dabs <= d_abs[WB-1:0];
        r_d1_prog <= prog;
        r_d1_lim  <= r_best_sq < SQ'(r_lim_sq);
        r_d1_dir  <= r_best_sq < SQ'(r_mgd_sq);
        r_d2_abs  <= d2_diff[PW] ? (PW+1)'(-d2_diff) : (PW+1)'(d2_diff);
        r_d2_rhs  <= r_d1_thab * r_d1_dabs;
        r_d2_prog <= r_d1_prog;
        r_d2_lim  <= r_d1_lim;
        r_d2_dir  <= r_d1_dir;
        r_bridge  <= r_d2_prog && r_d2_lim &&
                     ((CMPW'(r_d2_abs) << 4) < CMPW'(r_d2_rhs));
        r_direct  <= r_d2_dir;
    end

    assign acc_ok = r_direct || ((r_acc == 3'(RN)) && r_bridge);

    nnhco_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.dec_go),
        .i_value(r_best_sq), .o_done(sqrt_done), .o_root(root));

    assign gap_sat = (root > nnhco_pkg::ROOT_W'(nnhco_pkg::GAP_MAX))
        ? nnhco_pkg::GAP_MAX : root[GW-1:0];

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.err) begin
            o_wire   <= '0;
            o_time   <= '0;
            o_gap    <= '0;
            o_status <= i_start_set ? nnhco_pkg::ST_RANGE : nnhco_pkg::ST_NO_START;
            o_last   <= 1'b1;
        end else if (i_cmd.out_lat) begin
            o_wire   <= hit_w;
            o_time   <= hit_t;
            o_gap    <= gap_rd;
            o_status <= nnhco_pkg::ST_OK;
            o_last   <= (r_k == r_clen - 1'b1);
        end
    end

    assign o_sts.is_order  = (i_command == nnhco_pkg::CMD_ORDER);
    assign o_sts.start_set = i_start_set;
    assign o_sts.start_oor = (CW'(i_start_index) >= r_loaded);
    assign o_sts.rem_zero  = (r_rem == '0);
    assign o_sts.scan_done = !r_scan_run && !r_s1_vld && !r_s2_vld;
    assign o_sts.sqrt_done = sqrt_done;
    assign o_sts.out_last  = (r_k == r_clen - 1'b1);

endmodule

/* tb/testbench.sv */
// Testbench for nearest_neighbor_hit_chain_orderer: a scoreboard class predicts
// each chain run from the hits it saw loaded; plain tasks drive the streams.
// Depends on nnhco_pkg and the design top level.
`timescale 1ns / 1ps

module testbench;
    import nnhco_pkg::*;

    typedef struct {
        logic [WIRE_BITS-1:0] wire_num;
        logic [TIME_BITS-1:0] tick;
        logic [GAP_W-1:0]     gap;
        logic [STATUS_W-1:0]  status;
        logic                 is_last;
    } t_chain_hit;

    class t_chain_scoreboard;
        longint max_gap;
        longint slope_thr;
        logic [WIRE_BITS-1:0] wires[MAX_HITS];
        logic [TIME_BITS-1:0] ticks[MAX_HITS];
        bit taken[MAX_HITS];
        int loaded;
        longint rw[RECENT_N];
        longint rt[RECENT_N];
        int accepted;
        t_chain_hit pending_q[$];
        int errors;

        function void add_expected(t_chain_hit e);
            pending_q.insert(pending_q.size(), e);
        endfunction

        function longint floor_root(longint v);
            longint r;
            longint c;
            r = 0;
            for (int b = 20; b >= 0; b--) begin
                c = r | (longint'(1) << b);
                if (c * c <= v) r = c;
            end
            return r;
        endfunction

        function longint gap_of(longint sq);
            longint r;
            r = floor_root(sq);
            return (r > 65535) ? 65535 : r;
        endfunction

        function longint sq_between(int a, int b);
            longint dt;
            longint dw;
            dt = longint'(ticks[a]) - longint'(ticks[b]);
            dw = (longint'(wires[a]) - longint'(wires[b])) * 16;
            return dt * dt + dw * dw;
        endfunction

        function void push_recent(int idx);
            for (int k = 0; k < RECENT_N - 1; k++) begin
                rw[k] = rw[k + 1];
                rt[k] = rt[k + 1];
            end
            rw[RECENT_N - 1] = wires[idx];
            rt[RECENT_N - 1] = ticks[idx];
            accepted++;
        endfunction

        // gap bridging: keep wire direction, stay within extended limit, similar slope
        function bit can_bridge(int cand, longint sq);
            longint w1, t1, w2, t2, w3, t3, lim, a, b, c, d, diff;
            bit prog;
            w1 = rw[0]; t1 = rt[0];
            w2 = rw[RECENT_N - 1]; t2 = rt[RECENT_N - 1];
            w3 = wires[cand]; t3 = ticks[cand];
            lim = max_gap + 800;
            prog = (w1 < w2 && w3 > w2) || (w2 < w1 && w3 < w2);
            if (!prog || sq >= lim * lim) return 0;
            a = t2 - t1; b = w2 - w1; c = t3 - t2; d = w3 - w2;
            diff = c * b - a * d;
            if (diff < 0) diff = -diff;
            if (b < 0) b = -b;
            if (d < 0) d = -d;
            return 16 * diff < slope_thr * b * d;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_MAX_GAP) max_gap = val;
            else if (idx == REG_SLOPE) slope_thr = val;
        endfunction

        function void note_item(logic cmd, logic [WIRE_BITS-1:0] w, logic [TIME_BITS-1:0] t,
                                logic sset, logic [IDX_W-1:0] sidx);
            int chain[MAX_HITS];
            longint gaps[MAX_HITS];
            logic [WIRE_BITS-1:0] nw[MAX_HITS];
            logic [TIME_BITS-1:0] nt[MAX_HITS];
            int clen, best, remaining;
            longint best_sq, sq, last_sq;
            bit found, sentinel;
            t_chain_hit r;
            if (cmd == CMD_LOAD) begin
                if (loaded < MAX_HITS) begin
                    wires[loaded] = w;
                    ticks[loaded] = t;
                    loaded++;
                end
                return;
            end
            if (!sset || sidx >= loaded) begin
                r = '{0, 0, 0, sset ? ST_RANGE : ST_NO_START, 1'b1};
                add_expected(r);
                return;
            end
            foreach (taken[k]) taken[k] = 0;
            foreach (rw[k]) begin
                rw[k] = 0;
                rt[k] = 0;
            end
            accepted = 0;
            last_sq = 0;
            sentinel = 1;
            chain[0] = sidx;
            clen = 1;
            taken[sidx] = 1;
            push_recent(sidx);
            remaining = loaded - 1;
            while (remaining > 0) begin
                found = 0;
                best = 0;
                best_sq = 0;
                for (int i = 0; i < loaded; i++) begin
                    if (taken[i]) continue;
                    sq = sq_between(chain[clen - 1], i);
                    if (!found || sq < best_sq) begin
                        found = 1;
                        best = i;
                        best_sq = sq;
                    end
                end
                sentinel = 0;
                last_sq = best_sq;
                if (best_sq < max_gap * max_gap ||
                    (accepted >= 6 && can_bridge(best, best_sq))) begin
                    gaps[clen - 1] = gap_of(best_sq);
                    chain[clen++] = best;
                    push_recent(best);
                end
                taken[best] = 1;
                remaining--;
            end
            gaps[clen - 1] = sentinel ? 65535 : gap_of(last_sq);
            for (int k = 0; k < clen; k++) begin
                nw[k] = wires[chain[k]];
                nt[k] = ticks[chain[k]];
                r = '{nw[k], nt[k], gaps[k][GAP_W-1:0], ST_OK, k + 1 == clen};
                add_expected(r);
            end
            // the chain replaces the hit store
            for (int k = 0; k < clen; k++) begin
                wires[k] = nw[k];
                ticks[k] = nt[k];
            end
            foreach (taken[k]) taken[k] = 0;
            loaded = clen;
        endfunction

        function void check_result(logic [47:0] data, logic [1:0] user, logic lst);
            t_chain_hit e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result data=%h user=%h last=%b", $time, data, user, lst);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (data[12:0] !== e.wire_num) begin
                $display("%0t: out_wire expected %0d actual %0d", $time, e.wire_num, data[12:0]);
                errors++;
            end
            if (data[30:13] !== e.tick) begin
                $display("%0t: out_time expected %0d actual %0d", $time, e.tick, data[30:13]);
                errors++;
            end
            if (data[46:31] !== e.gap) begin
                $display("%0t: gap_distance expected %0d actual %0d", $time, e.gap, data[46:31]);
                errors++;
            end
            if (user !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, user);
                errors++;
            end
            if (lst !== e.is_last) begin
                $display("%0t: last expected %b actual %b", $time, e.is_last, lst);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    nearest_neighbor_hit_chain_orderer dut (.*);

    t_chain_scoreboard chain_sb = new;
    bit send_idle_en;
    bit sink_idle_en;
    int sink_stall;
    int items_sent;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
            sink_stall = $urandom_range(1, 18) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            chain_sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    task automatic send_item(logic cmd, logic [WIRE_BITS-1:0] w, logic [TIME_BITS-1:0] t,
                             logic sset, logic [IDX_W-1:0] sidx);
        if (send_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, sidx, sset, t, w};
        do @(posedge i_clk); while (!s_axis_tready);
        chain_sb.note_item(cmd, w, t, sset, sidx);
        items_sent++;
    endtask

    task automatic send_hit(int w, int t);
        send_item(CMD_LOAD, w[WIRE_BITS-1:0], t[TIME_BITS-1:0], 1'b0, '0);
    endtask

    task automatic send_order(logic sset, int sidx);
        send_item(CMD_ORDER, WIRE_BITS'($urandom), TIME_BITS'($urandom), sset,
                  sidx[IDX_W-1:0]);
    endtask

    // hold the stream until every expected result is out, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chain_sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        chain_sb.note_config(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_reg(int lo, int hi);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic track_phase();
        int n, w, dir, t, slope, step;
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 66) : $urandom_range(2, 12);
        w = $urandom_range(0, 8191);
        t = $urandom_range(0, 262143);
        dir = $urandom_range(0, 1) ? 1 : -1;
        slope = $urandom_range(0, 200);
        for (int k = 0; k < n; k++) begin
            send_hit(w, t + $urandom_range(0, 8));
            step = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
            w += dir * step;
            t += slope * step;
        end
        send_order($urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0 ?
                   $urandom_range(0, 63) : $urandom_range(0, n - 1));
        if ($urandom_range(0, 2) == 0)
            send_order(1'b1, $urandom_range(0, 63));
    endtask

    task automatic noise_phase();
        int n;
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0)
                send_order(1'($urandom_range(0, 1)), $urandom_range(0, 63));
            else
                send_hit($urandom, $urandom);
        end
        send_order(1'b1, $urandom_range(0, 63));
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        send_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (5) @(posedge i_clk);

        // empty store, missing start
        send_order(1'b1, 0);
        send_order(1'b0, 0);
        drain();
        write_reg(REG_MAX_GAP, '1);
        write_reg(REG_SLOPE, '0);
        // single hit at the field maxima, then a pair too far apart to link
        send_hit(8191, 262143);
        send_order(1'b1, 0);
        send_hit(0, 0);
        send_order(1'b1, 1);
        send_order(1'b1, 63);
        drain();
        write_reg(REG_MAX_GAP, 16'd300);
        write_reg(REG_SLOPE, '1);
        // straight track with a wire jump in the middle, still short enough to link directly
        for (int k = 0; k < 10; k++)
            send_hit(100 + k + ((k > 6) ? 6 : 0), 1000 + 40 * k);
        send_order(1'b1, 0);
        drain();

        while (items_sent < 480) begin
            if (items_sent > 430) begin
                send_idle_en = 1'b0;
                sink_idle_en = 1'b0;
            end else begin
                send_idle_en = $urandom_range(0, 3) != 0;
                sink_idle_en = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 2) == 0) begin
                drain();
                write_reg(REG_MAX_GAP, pick_reg(50, 400));
                write_reg(REG_SLOPE, pick_reg(0, 20000));
            end
            if ($urandom_range(0, 9) < 7) track_phase();
            else noise_phase();
            if ($urandom_range(0, 3) == 0) drain();
        end
        drain();
        repeat (60) @(posedge i_clk);
        if (chain_sb.errors == 0 && chain_sb.pending_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
